// ----- design/pcbs_pkg.sv -----
// Package for the pulse-count backlight stepper: word types, phase and register codes.
package pcbs_pkg;

   localparam int LevelWidth = 6;
   localparam int TickWidth  = 10;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = TickWidth;

   localparam logic [LevelWidth-1:0] MaxLevelReset     = 6'd32;
   localparam logic [LevelWidth-1:0] RestartLevelReset = 6'd16;
   localparam logic [TickWidth-1:0]  UpLowReset        = 10'd10;
   localparam logic [TickWidth-1:0]  UpHighReset       = 10'd3;
   localparam logic [TickWidth-1:0]  DownLowReset      = 10'd200;
   localparam logic [TickWidth-1:0]  DownHighReset     = 10'd30;
   localparam logic [TickWidth-1:0]  OffHoldReset      = 10'd800;
   localparam logic [TickWidth-1:0]  EnableReset       = 10'd5;
   localparam logic [LevelWidth-1:0] LevelReset        = 6'd16;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HOLD   = 3'd1,
      PH_ENABLE = 3'd2,
      PH_UP_LO  = 3'd3,
      PH_UP_HI  = 3'd4,
      PH_DN_LO  = 3'd5,
      PH_DN_HI  = 3'd6
   } phase_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_MAX_LEVEL     = 3'd0,
      CSR_RESTART_LEVEL = 3'd1,
      CSR_UP_LOW        = 3'd2,
      CSR_UP_HIGH       = 3'd3,
      CSR_DOWN_LOW      = 3'd4,
      CSR_DOWN_HIGH     = 3'd5,
      CSR_OFF_HOLD      = 3'd6,
      CSR_ENABLE        = 3'd7
   } csr_index_type;

   localparam logic MODE_REQUEST = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   typedef struct packed {
      logic                  mode;
      logic [LevelWidth-1:0] req_level;
      logic                  power_on;
   } req_word_type;

   typedef struct packed {
      logic                  pin_out;
      logic                  busy_res;
      logic [LevelWidth-1:0] level_now;
      logic                  dropped;
   } rsp_word_type;

endpackage

// ----- design/pulse_count_backlight_stepper_top.sv -----
// Top level of the pulse-count backlight stepper: request/tick sequencer with output register.
// The rsp word of an accepted req word is loaded into the output register in the next cycle.
// Throughput: one word per cycle unless stalled; the single state update between the input and
// the output register is the only loop, and the output register frees each cycle it drains.
// req_ready is high whenever the output register is empty or being taken.
// Reset (synchronous, active high) restores register defaults, sets the level to 16,
// the phase to idle, the pin low, and empties the output register.
module pulse_count_backlight_stepper_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pcbs_pkg::req_word_type     req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pcbs_pkg::rsp_word_type     rsp_word,
   input  logic                       csr_we,
   input  logic [pcbs_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [pcbs_pkg::CsrDataWidth-1:0] csr_wdata
);
   import pcbs_pkg::*;

   // Configuration registers
   logic [LevelWidth-1:0] max_level_ff, restart_level_ff;
   logic [TickWidth-1:0]  up_low_ff, up_high_ff, down_low_ff, down_high_ff;
   logic [TickWidth-1:0]  off_hold_ff, enable_ff;

   // Sequencer state
   phase_type             phase_ff, phase_in;
   logic [LevelWidth-1:0] current_level_ff, current_level_in;
   logic [LevelWidth-1:0] target_level_ff, target_level_in;
   logic [TickWidth-1:0]  countdown_ff, countdown_in;
   logic [LevelWidth-1:0] pulses_left_ff, pulses_left_in;
   logic                  pin_ff, pin_in;
   logic                  dropped;

   // Output register
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  req_take;
   logic [LevelWidth-1:0] clamped;
   logic [LevelWidth-1:0] pul_target, pul_base, pul_up_cnt, pul_dn_cnt;
   logic                  pul_up, pul_dn;

   // Output register drains and refills in the same cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff     <= MaxLevelReset;
         restart_level_ff <= RestartLevelReset;
         up_low_ff        <= UpLowReset;
         up_high_ff       <= UpHighReset;
         down_low_ff      <= DownLowReset;
         down_high_ff     <= DownHighReset;
         off_hold_ff      <= OffHoldReset;
         enable_ff        <= EnableReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_LEVEL:     max_level_ff     <= csr_wdata[LevelWidth-1:0];
            CSR_RESTART_LEVEL: restart_level_ff <= csr_wdata[LevelWidth-1:0];
            CSR_UP_LOW:        up_low_ff        <= csr_wdata;
            CSR_UP_HIGH:       up_high_ff       <= csr_wdata;
            CSR_DOWN_LOW:      down_low_ff      <= csr_wdata;
            CSR_DOWN_HIGH:     down_high_ff     <= csr_wdata;
            CSR_OFF_HOLD:      off_hold_ff      <= csr_wdata;
            CSR_ENABLE:        enable_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request level saturates at max_level
   assign clamped = (req_word.req_level > max_level_ff) ? max_level_ff : req_word.req_level;

   // Pulse train start: from a request it steps current -> clamped, at the end of
   // the enable settle it steps restart_level -> stored target.
   assign pul_target = (req_word.mode == MODE_REQUEST) ? clamped : target_level_ff;
   assign pul_base   = (req_word.mode == MODE_REQUEST) ? current_level_ff : restart_level_ff;
   assign pul_up     = pul_target > pul_base;
   assign pul_dn     = pul_target < pul_base;
   assign pul_up_cnt = pul_target - pul_base;
   assign pul_dn_cnt = pul_base - pul_target;

   // Next state
   always_comb begin
      phase_in         = phase_ff;
      current_level_in = current_level_ff;
      target_level_in  = target_level_ff;
      countdown_in     = countdown_ff;
      pulses_left_in   = pulses_left_ff;
      pin_in           = pin_ff;
      dropped          = 1'b0;

      if (req_word.mode == MODE_TICK) begin
         if (phase_ff != PH_IDLE) begin
            if (countdown_ff <= TickWidth'(1)) begin
               // phase ends on this tick; zero loads behave as one
               countdown_in = '0;
               unique case (phase_ff)
                  PH_HOLD: begin
                     current_level_in = '0;
                     phase_in         = PH_IDLE;
                  end
                  PH_ENABLE: begin
                     current_level_in = restart_level_ff;
                     if (pul_up) begin
                        pulses_left_in = pul_up_cnt;
                        phase_in       = PH_UP_LO;
                        pin_in         = 1'b0;
                        countdown_in   = up_low_ff;
                     end else if (pul_dn) begin
                        pulses_left_in = pul_dn_cnt;
                        phase_in       = PH_DN_LO;
                        pin_in         = 1'b0;
                        countdown_in   = down_low_ff;
                     end else begin
                        pulses_left_in = '0;
                        phase_in       = PH_IDLE;
                     end
                  end
                  PH_UP_LO: begin
                     pin_in       = 1'b1;
                     phase_in     = PH_UP_HI;
                     countdown_in = up_high_ff;
                  end
                  PH_DN_LO: begin
                     pin_in       = 1'b1;
                     phase_in     = PH_DN_HI;
                     countdown_in = down_high_ff;
                  end
                  PH_UP_HI, PH_DN_HI: begin
                     if (phase_ff == PH_UP_HI) begin
                        current_level_in = current_level_ff + LevelWidth'(1);
                     end else begin
                        current_level_in = current_level_ff - LevelWidth'(1);
                     end
                     pulses_left_in   = pulses_left_ff - LevelWidth'(1);
                     if (pulses_left_in == '0) begin
                        phase_in = PH_IDLE;
                     end else if (phase_ff == PH_UP_HI) begin
                        pin_in       = 1'b0;
                        phase_in     = PH_UP_LO;
                        countdown_in = up_low_ff;
                     end else begin
                        pin_in       = 1'b0;
                        phase_in     = PH_DN_LO;
                        countdown_in = down_low_ff;
                     end
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end else begin
               countdown_in = countdown_ff - TickWidth'(1);
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         dropped = 1'b1;
      end else if (!req_word.power_on) begin
         pin_in = 1'b0;
      end else begin
         target_level_in = clamped;
         if (clamped == '0) begin
            pin_in       = 1'b0;
            phase_in     = PH_HOLD;
            countdown_in = off_hold_ff;
         end else if (current_level_ff == '0) begin
            pin_in       = 1'b1;
            phase_in     = PH_ENABLE;
            countdown_in = enable_ff;
         end else if (pul_up) begin
            pulses_left_in = pul_up_cnt;
            phase_in       = PH_UP_LO;
            pin_in         = 1'b0;
            countdown_in   = up_low_ff;
         end else if (pul_dn) begin
            pulses_left_in = pul_dn_cnt;
            phase_in       = PH_DN_LO;
            pin_in         = 1'b0;
            countdown_in   = down_low_ff;
         end else begin
            pulses_left_in = '0;
         end
      end
   end

   // Result word reflects the state after this word
   always_comb begin
      rsp_word_in.pin_out   = pin_in;
      rsp_word_in.busy_res  = (phase_in != PH_IDLE);
      rsp_word_in.level_now = current_level_in;
      rsp_word_in.dropped   = dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         current_level_ff <= LevelReset;
         target_level_ff  <= LevelReset;
         countdown_ff     <= '0;
         pulses_left_ff   <= '0;
         pin_ff           <= 1'b0;
      end else if (req_take) begin
         phase_ff         <= phase_in;
         current_level_ff <= current_level_in;
         target_level_ff  <= target_level_in;
         countdown_ff     <= countdown_in;
         pulses_left_ff   <= pulses_left_in;
         pin_ff           <= pin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

// ----- design/pcbs_checker.sv -----
// Port-level checker for the backlight stepper, bound to the top level.
module pcbs_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input pcbs_pkg::req_word_type req_word,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input pcbs_pkg::rsp_word_type rsp_word
);
   import pcbs_pkg::*;

   // output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   // an empty output register never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

   // every accepted tick yields a result next cycle; ticks are never dropped
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.mode == MODE_TICK |=> rsp_valid && !rsp_word.dropped)
      else $error("tick result missing or flagged dropped");

   // a dropped request means a sequence is still running
   a_drop_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.dropped |-> rsp_word.busy_res)
      else $error("dropped request while not busy");

endmodule

bind pulse_count_backlight_stepper_top pcbs_checker u_pcbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

// ----- tb/tb_pulse_count_backlight_stepper_top.sv -----
// Self-checking testbench for the pulse-count backlight stepper: directed plan, then random phases.
module tb_pulse_count_backlight_stepper_top;
   import pcbs_pkg::*;

   // Generous bound: ~1000 words at worst-case gap plus stall stay well inside it.
   localparam int CycleLimit  = 500000;
   localparam int RandomWords = 400;

   // ---------------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ---------------------------------------------------------------------------------
   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_word_type            req_word  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_word_type            rsp_word;
   logic                    csr_we    = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   pulse_count_backlight_stepper_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Stepper predictor: register mirror plus sequencer state
   // ---------------------------------------------------------------------------------
   logic [LevelWidth-1:0] cfg_max, cfg_restart;
   logic [TickWidth-1:0]  cfg_up_lo, cfg_up_hi, cfg_dn_lo, cfg_dn_hi, cfg_hold, cfg_enable;

   logic [LevelWidth-1:0] cur_level, tgt_level, pulses;
   logic [TickWidth-1:0]  countdown;
   phase_type             ph;
   logic                  pin;

   // Predicted status words, oldest first
   rsp_word_type status_due[$];

   int  mismatches = 0;
   int  rsp_seen   = 0;
   int  cycles     = 0;
   logic send_calm = 1'b0;   // sender runs with no gaps while set
   logic csr_open  = 1'b0;   // csr_we still high after the last register write

   // What the sender is offering: a hand-typed status word, if any
   logic         word_typed = 1'b0;
   rsp_word_type word_want  = '0;

   // Load the pulse train toward the target, or go idle if already there.
   function automatic void start_pulses();
      if (tgt_level > cur_level) begin
         pulses    = tgt_level - cur_level;
         ph        = PH_UP_LO;
         pin       = 1'b0;
         countdown = cfg_up_lo;
      end else if (tgt_level < cur_level) begin
         pulses    = cur_level - tgt_level;
         ph        = PH_DN_LO;
         pin       = 1'b0;
         countdown = cfg_dn_lo;
      end else begin
         pulses = '0;
         ph     = PH_IDLE;
      end
   endfunction

   // Countdown expired: move to the next phase.
   function automatic void end_phase();
      case (ph)
         PH_HOLD: begin
            cur_level = '0;
            ph        = PH_IDLE;
         end
         PH_ENABLE: begin
            // converter wakes at restart level, even above max or zero
            cur_level = cfg_restart;
            start_pulses();
         end
         PH_UP_LO: begin
            pin       = 1'b1;
            ph        = PH_UP_HI;
            countdown = cfg_up_hi;
         end
         PH_DN_LO: begin
            pin       = 1'b1;
            ph        = PH_DN_HI;
            countdown = cfg_dn_hi;
         end
         PH_UP_HI, PH_DN_HI: begin
            // level moves at the end of each high time
            if (ph == PH_UP_HI) cur_level = cur_level + 6'd1;
            else                cur_level = cur_level - 6'd1;
            pulses = pulses - 6'd1;
            if (pulses == '0) begin
               ph = PH_IDLE;
            end else if (ph == PH_UP_HI) begin
               pin       = 1'b0;
               ph        = PH_UP_LO;
               countdown = cfg_up_lo;
            end else begin
               pin       = 1'b0;
               ph        = PH_DN_LO;
               countdown = cfg_dn_lo;
            end
         end
         default: ph = PH_IDLE;
      endcase
   endfunction

   // One accepted word in, one status word out.
   function automatic rsp_word_type advance_stepper(req_word_type w);
      logic                  drop;
      logic [LevelWidth-1:0] lvl;
      rsp_word_type          r;
      drop = 1'b0;
      if (w.mode == MODE_TICK) begin
         if (ph != PH_IDLE) begin
            // a zero load ends on the next tick, same as a load of one
            if (countdown <= 10'd1) begin
               countdown = '0;
               end_phase();
            end else begin
               countdown = countdown - 10'd1;
            end
         end
      end else if (ph != PH_IDLE) begin
         drop = 1'b1;                    // busy: request ignored, power bit too
      end else if (!w.power_on) begin
         pin = 1'b0;                     // power off: pin low, levels kept
      end else begin
         lvl       = (w.req_level > cfg_max) ? cfg_max : w.req_level;
         tgt_level = lvl;
         if (lvl == '0) begin
            pin       = 1'b0;
            ph        = PH_HOLD;
            countdown = cfg_hold;
         end else if (cur_level == '0) begin
            pin       = 1'b1;
            ph        = PH_ENABLE;
            countdown = cfg_enable;
         end else begin
            start_pulses();
         end
      end
      r.pin_out   = pin;
      r.busy_res  = (ph != PH_IDLE);
      r.level_now = cur_level;
      r.dropped   = drop;
      return r;
   endfunction

   function automatic rsp_word_type mk_status(int p, int b, int l, int d);
      rsp_word_type r;
      r.pin_out   = p[0];
      r.busy_res  = b[0];
      r.level_now = l[LevelWidth-1:0];
      r.dropped   = d[0];
      return r;
   endfunction

   // Register value for a level register: often the extremes, zero now and then.
   function automatic logic [LevelWidth-1:0] pick_level6();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)      return '0;
      else if (r <= 3) return 6'd1;
      else if (r <= 7) return 6'd63;
      else             return 6'($urandom_range(1, 63));
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch at rsp word %0d: %s is %0d, predicted %0d", rsp_seen, what, got, want);
   endtask

   // ---------------------------------------------------------------------------------
   // Scoreboard: check the oldest prediction, then predict the newly accepted word
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type due, model;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               flag_mismatch("unexpected rsp word, pending count", 0, 0);
            end else begin
               due = status_due.pop_front();
               if (rsp_word.pin_out !== due.pin_out)
                  flag_mismatch("pin_out", int'(rsp_word.pin_out), int'(due.pin_out));
               if (rsp_word.busy_res !== due.busy_res)
                  flag_mismatch("busy_res", int'(rsp_word.busy_res), int'(due.busy_res));
               if (rsp_word.level_now !== due.level_now)
                  flag_mismatch("level_now", int'(rsp_word.level_now), int'(due.level_now));
               if (rsp_word.dropped !== due.dropped)
                  flag_mismatch("dropped", int'(rsp_word.dropped), int'(due.dropped));
            end
            rsp_seen++;
         end
         if (req_valid && req_ready) begin
            // predictor runs on every word so its state stays in step
            model = advance_stepper(req_word);
            status_due.push_back(word_typed ? word_want : model);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d rsp words pending", cycles, status_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Response side: random stalls, with calm stretches every so often
   // ---------------------------------------------------------------------------------
   initial begin
      int   stall;
      int   taken;
      logic rsp_calm;
      taken    = 0;
      rsp_calm = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (taken % 24 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
         stall = rsp_calm ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------------------
   // Request-side tasks; all are entered and left at a falling edge
   // ---------------------------------------------------------------------------------
   task automatic send_word(input req_word_type w, input logic typed, input rsp_word_type want);
      int gap;
      if (csr_open) begin
         csr_we   <= 1'b0;
         csr_open  = 1'b0;
      end
      gap = send_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_word   <= w;
      word_typed <= typed;
      word_want  <= want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stop offering words and wait until every predicted status word is back.
   task automatic settle();
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(negedge clock);
   endtask

   // Register write; the mirror is updated now since nothing is in flight.
   task automatic write_csr(input csr_index_type idx, input logic [CsrDataWidth-1:0] data);
      case (idx)
         CSR_MAX_LEVEL:     cfg_max     = data[LevelWidth-1:0];
         CSR_RESTART_LEVEL: cfg_restart = data[LevelWidth-1:0];
         CSR_UP_LOW:        cfg_up_lo   = data;
         CSR_UP_HIGH:       cfg_up_hi   = data;
         CSR_DOWN_LOW:      cfg_dn_lo   = data;
         CSR_DOWN_HIGH:     cfg_dn_hi   = data;
         CSR_OFF_HOLD:      cfg_hold    = data;
         CSR_ENABLE:        cfg_enable  = data;
         default: ;
      endcase
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_open = 1'b1;
   endtask

   // ---------------------------------------------------------------------------------
   // Directed plan
   // ---------------------------------------------------------------------------------
   typedef struct {
      logic                    is_csr;
      csr_index_type           idx;
      logic [CsrDataWidth-1:0] data;
      req_word_type            word;
      int                      reps;
      logic                    typed;
      rsp_word_type            want;
   } plan_row_type;

   function automatic plan_row_type csr_row(csr_index_type i, logic [CsrDataWidth-1:0] d);
      plan_row_type r;
      r        = '{default: '0, idx: CSR_MAX_LEVEL};
      r.is_csr = 1'b1;
      r.idx    = i;
      r.data   = d;
      return r;
   endfunction

   function automatic plan_row_type word_row(logic m, logic [5:0] l, logic p, int n,
                                             logic typed, rsp_word_type want);
      plan_row_type r;
      r                = '{default: '0, idx: CSR_MAX_LEVEL};
      r.word.mode      = m;
      r.word.req_level = l;
      r.word.power_on  = p;
      r.reps           = n;
      r.typed          = typed;
      r.want           = want;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin
      plan_row_type          plan[$];
      req_word_type          w;
      logic                  last_word;
      logic                  is_tick;
      logic [CsrDataWidth-1:0] cfg_word;
      logic [TickWidth-1:0]  tick_val[6];
      logic [LevelWidth-1:0] max6, restart6;
      int                    slow_reg;
      int                    phase_no;
      int                    n_target;
      int                    k;
      int                    random_count;
      int                    r;

      // predictor matches the register and state defaults after reset
      cfg_max    = MaxLevelReset;
      cfg_restart = RestartLevelReset;
      cfg_up_lo  = UpLowReset;
      cfg_up_hi  = UpHighReset;
      cfg_dn_lo  = DownLowReset;
      cfg_dn_hi  = DownHighReset;
      cfg_hold   = OffHoldReset;
      cfg_enable = EnableReset;
      cur_level  = LevelReset;
      tgt_level  = LevelReset;
      pulses     = '0;
      countdown  = '0;
      ph         = PH_IDLE;
      pin        = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default registers: tick while idle, power-off request, same level requested
      plan.push_back(word_row(MODE_TICK,    6'd0,  1'b0, 1, 1'b1, mk_status(0, 0, 16, 0)));
      plan.push_back(word_row(MODE_REQUEST, 6'd63, 1'b0, 1, 1'b1, mk_status(0, 0, 16, 0)));
      plan.push_back(word_row(MODE_REQUEST, 6'd16, 1'b1, 1, 1'b1, mk_status(0, 0, 16, 0)));
      // Short timings, zero loads on up-high and off-hold, restart above max
      plan.push_back(csr_row(CSR_MAX_LEVEL,     10'd20));
      plan.push_back(csr_row(CSR_RESTART_LEVEL, 10'd23));
      plan.push_back(csr_row(CSR_UP_LOW,        10'd1));
      plan.push_back(csr_row(CSR_UP_HIGH,       10'd0));
      plan.push_back(csr_row(CSR_DOWN_LOW,      10'd1));
      plan.push_back(csr_row(CSR_DOWN_HIGH,     10'd1));
      plan.push_back(csr_row(CSR_OFF_HOLD,      10'd0));
      plan.push_back(csr_row(CSR_ENABLE,        10'd2));
      // 63 saturates to 20: four up pulses; a power-off request meanwhile is dropped
      plan.push_back(word_row(MODE_REQUEST, 6'd63, 1'b1, 1, 1'b1, mk_status(0, 1, 16, 0)));
      plan.push_back(word_row(MODE_REQUEST, 6'd0,  1'b0, 1, 1'b1, mk_status(0, 1, 16, 1)));
      plan.push_back(word_row(MODE_TICK,    6'd0,  1'b0, 8, 1'b0, '0));
      // switch off; zero hold ends on the first tick
      plan.push_back(word_row(MODE_REQUEST, 6'd0,  1'b1, 1, 1'b1, mk_status(0, 1, 20, 0)));
      plan.push_back(word_row(MODE_TICK,    6'd0,  1'b0, 1, 1'b1, mk_status(0, 0, 0, 0)));
      // wake from off: settle, restart at 23, then step down to 20
      plan.push_back(word_row(MODE_REQUEST, 6'd40, 1'b1, 1, 1'b1, mk_status(1, 1, 0, 0)));
      plan.push_back(word_row(MODE_TICK,    6'd63, 1'b1, 8, 1'b0, '0));
      // power off drops the high pin but keeps the level
      plan.push_back(word_row(MODE_REQUEST, 6'd9,  1'b0, 1, 1'b1, mk_status(0, 0, 20, 0)));
      plan.push_back(word_row(MODE_TICK,    6'd42, 1'b1, 1, 1'b1, mk_status(0, 0, 20, 0)));

      last_word = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            if (last_word) settle();
            last_word = 1'b0;
            write_csr(plan[i].idx, plan[i].data);
         end else begin
            repeat (plan[i].reps) send_word(plan[i].word, plan[i].typed, plan[i].want);
            last_word = 1'b1;
         end
      end

      // Random phases: new registers while drained, then a burst of words
      // steered by the predicted phase so that sequences actually run.
      random_count = 0;
      phase_no     = 0;
      while (random_count < RandomWords) begin
         settle();
         if (phase_no == 0) begin
            // fastest timing, widest range, lowest nonzero restart
            max6     = 6'd63;
            restart6 = 6'd1;
            foreach (tick_val[j]) tick_val[j] = 10'd1;
         end else if (phase_no == 1) begin
            // narrowest nonzero range, top restart, one timing at its ceiling
            max6     = 6'd1;
            restart6 = 6'd63;
            foreach (tick_val[j]) tick_val[j] = 10'd0;
            tick_val[$urandom_range(0, 5)] = 10'd1023;
         end else begin
            max6     = pick_level6();
            restart6 = pick_level6();
            slow_reg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 6;
            foreach (tick_val[j]) begin
               if (j == slow_reg)
                  tick_val[j] = $urandom_range(0, 1) ? 10'd1023 : 10'($urandom_range(1, 1023));
               else
                  tick_val[j] = 10'($urandom_range(0, 4));
            end
         end
         // upper data bits of the level registers are junk and must be ignored
         cfg_word = 10'($urandom_range(0, 1023));
         cfg_word[LevelWidth-1:0] = max6;
         write_csr(CSR_MAX_LEVEL, cfg_word);
         cfg_word = 10'($urandom_range(0, 1023));
         cfg_word[LevelWidth-1:0] = restart6;
         write_csr(CSR_RESTART_LEVEL, cfg_word);
         write_csr(CSR_UP_LOW,    tick_val[0]);
         write_csr(CSR_UP_HIGH,   tick_val[1]);
         write_csr(CSR_DOWN_LOW,  tick_val[2]);
         write_csr(CSR_DOWN_HIGH, tick_val[3]);
         write_csr(CSR_OFF_HOLD,  tick_val[4]);
         write_csr(CSR_ENABLE,    tick_val[5]);

         n_target  = $urandom_range(20, 45);
         send_calm = ($urandom_range(0, 3) == 0);
         k = 0;
         // run until the target is reached with the sequencer idle, or a cap
         while (!(k >= n_target && ph == PH_IDLE) && k < 4 * n_target) begin
            if (ph != PH_IDLE) is_tick = ($urandom_range(0, 99) < 85);
            else               is_tick = ($urandom_range(0, 99) < 30);
            w.mode = is_tick ? MODE_TICK : MODE_REQUEST;
            r = $urandom_range(0, 9);
            if (r == 0)      w.req_level = '0;
            else if (r == 1) w.req_level = cur_level;
            else if (r == 2) w.req_level = 6'd63;
            else             w.req_level = 6'($urandom_range(0, 63));
            w.power_on = ($urandom_range(0, 99) < 85);
            random_count++;
            send_word(w, 1'b0, '0);
            k++;
         end
         phase_no++;
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- pulse_count_backlight_stepper_top.f -----
design/pcbs_pkg.sv
design/pulse_count_backlight_stepper_top.sv
design/pcbs_checker.sv
tb/tb_pulse_count_backlight_stepper_top.sv
